[hdl/evt_pkg.sv]
package evt_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_OUT_BITS    = 16;
  localparam logic [LEN_OUT_BITS-1:0] LEN_OUT_MAX = '1;

  // result queue: room for two results of one byte plus two in flight
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [2:0] {
    KIND_VAR     = 3'd0,
    KIND_VAR_DEF = 3'd1,
    KIND_ESCAPE  = 3'd2,
    KIND_TEXT    = 3'd3,
    KIND_ERROR   = 3'd4
  } evt_kind_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       last_byte;
  } evt_in_t;

  typedef struct packed {
    evt_kind_t                 token_kind;
    logic [LEN_OUT_BITS-1:0]   token_length;
    logic [LEN_OUT_BITS-1:0]   name_length;
    logic                      length_overflow;
    logic                      run_end;
  } evt_out_t;

  // results produced by one request, first slot always used before second
  typedef struct packed {
    logic     push0;
    logic     push1;
    evt_out_t res0;
    evt_out_t res1;
  } evt_push_t;

endpackage

[hdl/evt_scan.sv]
module evt_scan #(
  parameter int LENGTH_BITS = evt_pkg::LENGTH_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  evt_pkg::evt_in_t   in_data,
  output evt_pkg::evt_push_t push
);
  import evt_pkg::*;

  localparam int LB = LENGTH_BITS;
  localparam int EW = (LB > LEN_OUT_BITS) ? LB : LEN_OUT_BITS;
  localparam logic [LB-1:0] CNT_MAX = {LB{1'b1}};

  localparam logic [7:0] CH_DOLLAR = 8'd36;
  localparam logic [7:0] CH_LBRACE = 8'd123;
  localparam logic [7:0] CH_COLON  = 8'd58;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_RBRACE = 8'd125;

  typedef enum logic [6:0] {
    ST_START  = 7'b0000001,
    ST_TEXT   = 7'b0000010,
    ST_DOLLAR = 7'b0000100,
    ST_NAME   = 7'b0001000,
    ST_COLON  = 7'b0010000,
    ST_PLAIN  = 7'b0100000,
    ST_DEF    = 7'b1000000
  } evt_state_t;

  evt_state_t    state_r, state_nxt, state_m;
  logic [LB-1:0] cnt_r, cnt_nxt, cnt_m, cnt_inc, cnt0;
  logic [LB-1:0] col_r, col_nxt, col_m;
  logic          sat_r, sat_nxt, sat_m, sat_inc, sat0;
  logic          e0, e1, use_old;
  evt_kind_t     k0, k1;
  logic [EW-1:0] nm0;
  logic [7:0]    c;

  function automatic evt_out_t make_res(input evt_kind_t kind, input logic [LB-1:0] cnt,
                                        input logic sat, input logic [EW-1:0] nm,
                                        input logic re);
    evt_out_t      r;
    logic [EW-1:0] ext;
    ext = EW'(cnt);
    r.token_kind      = kind;
    r.token_length    = (ext > EW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : ext[LEN_OUT_BITS-1:0];
    r.name_length     = (nm > EW'(LEN_OUT_MAX)) ? LEN_OUT_MAX : nm[LEN_OUT_BITS-1:0];
    r.length_overflow = sat | (ext > EW'(LEN_OUT_MAX));
    r.run_end         = re;
    return r;
  endfunction

  assign c       = in_data.in_byte;
  assign cnt_inc = (cnt_r == CNT_MAX) ? cnt_r : cnt_r + LB'(1);
  assign sat_inc = sat_r | (cnt_r == CNT_MAX);

  always_comb begin
    state_m = state_r;
    cnt_m   = cnt_r;
    col_m   = col_r;
    sat_m   = sat_r;
    e0      = 1'b0;
    k0      = KIND_TEXT;
    nm0     = '0;
    use_old = 1'b0;
    unique case (state_r)
      ST_START: begin
        cnt_m   = LB'(1);
        col_m   = '0;
        sat_m   = 1'b0;
        state_m = (c == CH_DOLLAR) ? ST_DOLLAR : ST_TEXT;
      end
      ST_TEXT: begin
        if (c == CH_DOLLAR) begin
          // text run closes with its old count, the dollar opens a new token
          e0      = 1'b1;
          k0      = KIND_TEXT;
          use_old = 1'b1;
          cnt_m   = LB'(1);
          col_m   = '0;
          sat_m   = 1'b0;
          state_m = ST_DOLLAR;
        end else begin
          cnt_m = cnt_inc;
          sat_m = sat_inc;
        end
      end
      ST_DOLLAR: begin
        cnt_m = cnt_inc;
        sat_m = sat_inc;
        if (c == CH_DOLLAR) begin
          e0      = 1'b1;
          k0      = KIND_ESCAPE;
          state_m = ST_START;
        end else if (c == CH_LBRACE) begin
          state_m = ST_NAME;
        end else begin
          state_m = ST_TEXT;
        end
      end
      ST_NAME: begin
        cnt_m = cnt_inc;
        sat_m = sat_inc;
        if (c == CH_COLON) begin
          col_m   = cnt_inc - LB'(1);
          state_m = ST_COLON;
        end else if (c == CH_RBRACE) begin
          e0      = 1'b1;
          k0      = KIND_VAR;
          nm0     = EW'(cnt_inc) - EW'(3);
          state_m = ST_START;
        end
      end
      ST_COLON: begin
        cnt_m = cnt_inc;
        sat_m = sat_inc;
        if (c == CH_DASH) begin
          state_m = ST_DEF;
        end else if (c == CH_RBRACE) begin
          e0      = 1'b1;
          k0      = KIND_VAR;
          nm0     = EW'(cnt_inc) - EW'(3);
          state_m = ST_START;
        end else begin
          state_m = ST_PLAIN;
        end
      end
      ST_PLAIN: begin
        cnt_m = cnt_inc;
        sat_m = sat_inc;
        if (c == CH_RBRACE) begin
          e0      = 1'b1;
          k0      = KIND_VAR;
          nm0     = EW'(cnt_inc) - EW'(3);
          state_m = ST_START;
        end
      end
      ST_DEF: begin
        cnt_m = cnt_inc;
        sat_m = sat_inc;
        if (c == CH_RBRACE) begin
          e0      = 1'b1;
          k0      = KIND_VAR_DEF;
          nm0     = EW'(col_r) - EW'(2);
          state_m = ST_START;
        end
      end
      default: begin
        state_m = ST_START;
      end
    endcase
  end

  // end of string closes whatever is still open
  assign e1   = in_data.last_byte && (state_m != ST_START);
  assign k1   = (state_m == ST_TEXT) ? KIND_TEXT : KIND_ERROR;
  assign cnt0 = use_old ? cnt_r : cnt_m;
  assign sat0 = use_old ? sat_r : sat_m;

  always_comb begin
    push.push0 = accept && (e0 || e1);
    push.push1 = accept && e0 && e1;
    push.res1  = make_res(k1, cnt_m, sat_m, '0, 1'b1);
    if (e0) begin
      push.res0 = make_res(k0, cnt0, sat0, nm0, !e1);
    end else begin
      push.res0 = push.res1;
    end
  end

  always_comb begin
    if (in_data.last_byte) begin
      state_nxt = ST_START;
      cnt_nxt   = '0;
      col_nxt   = '0;
      sat_nxt   = 1'b0;
    end else begin
      state_nxt = state_m;
      cnt_nxt   = cnt_m;
      col_nxt   = col_m;
      sat_nxt   = sat_m;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_START;
      cnt_r   <= '0;
      col_r   <= '0;
      sat_r   <= 1'b0;
    end else if (accept) begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      col_r   <= col_nxt;
      sat_r   <= sat_nxt;
    end
  end

endmodule

[hdl/evt_outq.sv]
module evt_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  evt_pkg::evt_push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output evt_pkg::evt_out_t  out_data
);
  import evt_pkg::*;

  evt_out_t       q_r [QDEPTH];
  logic [QAW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;
  logic [QAW-1:0] wr1;

  assign out_valid = (cnt_r != '0);
  assign out_data  = q_r[rd_r];
  assign pop       = out_valid && out_ready;
  // a request may push two results, so keep two slots free
  assign room      = (cnt_r <= QCW'(QDEPTH - 2));
  assign wr1       = wr_r + QAW'(1);

  always_comb begin
    wr_nxt  = wr_r + QAW'(push.push0) + QAW'(push.push1);
    rd_nxt  = rd_r + QAW'(pop);
    cnt_nxt = cnt_r + QCW'(push.push0) + QCW'(push.push1) - QCW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.push0) begin
      q_r[wr_r] <= push.res0;
    end
    if (push.push1) begin
      q_r[wr1] <= push.res1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[hdl/env_var_expansion_tokenizer.sv]
// a result enters the result queue when the byte closing its token is accepted
// one byte per cycle while in_ready is high; a byte that closes two tokens pushes
//   two results, and a four-entry result queue absorbs that burst
// input is stalled only while fewer than two queue entries are free
// synchronous active-low reset returns the scanner to its start state and
//   empties the result queue
module env_var_expansion_tokenizer #(
  parameter int LENGTH_BITS = evt_pkg::LENGTH_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  evt_pkg::evt_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output evt_pkg::evt_out_t out_data
);
  import evt_pkg::*;

  evt_push_t push;
  logic      accept;

  assign accept = in_valid && in_ready;

  evt_scan #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .in_data(in_data),
    .push   (push)
  );

  evt_outq u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (in_ready),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
